// File: rtl/teq_pkg.sv
// Shared types and codes for the timed event queue.
package teq_pkg;

    localparam int KIND_W   = 2;
    localparam int TYPE_W   = 2;
    localparam int STATUS_W = 3;

    localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PROCESS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SCHEDULED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_PRC_CHK,
        S_PRC_CMP,
        S_RESP
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_ram_ctl;

endpackage

// File: rtl/timed_event_queue_top.sv
// Top level of the time-sorted event queue: stream ports, RAM, unit, sequencer.
//
//  channel  | dir | tdata (low bit up)                                   | tuser  | tlast
//  s_axis   | in  | time_value, handler_id, data_type, payload           | kind   | -
//  m_axis   | out | event_time, fired_handler, fired_type, fired_payload, | status | last
//           |     | now_time                                             |        |
//
// Schedule: each queued event later than the new one moves up one slot; a full queue rejects.
// Process: fires queued events due at or before the given time, head first.
// The single RAM read port and the shared compare make each step a read followed by a compare.
// Reset clears count, head and output valid; queue contents stay undefined.
// A stalled m_axis holds the sequencer in its fire or response step.
module timed_event_queue_top #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TIME_WIDTH    = 32,
    parameter int HANDLER_WIDTH = 8,
    parameter int PAYLOAD_WIDTH = 64,
    localparam int IDW = ((TIME_WIDTH + HANDLER_WIDTH + teq_pkg::TYPE_W
                          + PAYLOAD_WIDTH + 7) / 8) * 8,
    localparam int ODW = ((2 * TIME_WIDTH + HANDLER_WIDTH + teq_pkg::TYPE_W
                          + PAYLOAD_WIDTH + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // time_value, handler_id, data_type, payload
    input  logic [IDW-1:0]                i_s_axis_tdata,
    // kind
    input  logic [teq_pkg::KIND_W-1:0]    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // event_time, fired_handler, fired_type, fired_payload, now_time
    output logic [ODW-1:0]                o_m_axis_tdata,
    // status
    output logic [teq_pkg::STATUS_W-1:0]  o_m_axis_tuser,
    output logic                          o_m_axis_tlast
);

    import teq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int EW = TIME_WIDTH + HANDLER_WIDTH + TYPE_W + PAYLOAD_WIDTH;
    localparam int HL = TIME_WIDTH;
    localparam int YL = HL + HANDLER_WIDTH;
    localparam int PL = YL + TYPE_W;
    localparam int NL = PL + PAYLOAD_WIDTH;

    t_ram_ctl                  ram_ctl;
    logic [EW-1:0]             ram_wdata;
    logic [EW-1:0]             ram_q;
    logic [AW-1:0]             head;
    logic [AW-1:0]             idx;
    logic [AW-1:0]             addr;
    logic [TIME_WIDTH-1:0]     ref_time;
    logic                      gt;

    logic [TIME_WIDTH-1:0]     out_event_time;
    logic [HANDLER_WIDTH-1:0]  out_handler;
    logic [TYPE_W-1:0]         out_type;
    logic [PAYLOAD_WIDTH-1:0]  out_payload;
    logic [TIME_WIDTH-1:0]     out_now;

    teq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_ctl.we),
        .i_waddr (addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_ctl.re),
        .i_raddr (addr),
        .o_rdata (ram_q)
    );

    teq_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_unit (
        .i_head     (head),
        .i_idx      (idx),
        .i_q_time   (ram_q[TIME_WIDTH-1:0]),
        .i_ref_time (ref_time),
        .o_addr     (addr),
        .o_gt       (gt)
    );

    teq_seq #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TIME_WIDTH    (TIME_WIDTH),
        .HANDLER_WIDTH (HANDLER_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_s_axis_tvalid),
        .o_in_ready       (o_s_axis_tready),
        .i_in_kind        (i_s_axis_tuser),
        .i_in_time        (i_s_axis_tdata[HL-1:0]),
        .i_in_handler     (i_s_axis_tdata[YL-1:HL]),
        .i_in_type        (i_s_axis_tdata[PL-1:YL]),
        .i_in_payload     (i_s_axis_tdata[NL-1:PL]),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .o_out_status     (o_m_axis_tuser),
        .o_out_event_time (out_event_time),
        .o_out_handler    (out_handler),
        .o_out_type       (out_type),
        .o_out_payload    (out_payload),
        .o_out_now        (out_now),
        .o_out_last       (o_m_axis_tlast),
        .o_ram_ctl        (ram_ctl),
        .o_ram_wdata      (ram_wdata),
        .i_ram_q          (ram_q),
        .o_head           (head),
        .o_idx            (idx),
        .o_ref_time       (ref_time),
        .i_addr           (addr),
        .i_gt             (gt)
    );

    always_comb begin
        o_m_axis_tdata                        = '0;
        o_m_axis_tdata[HL-1:0]                = out_event_time;
        o_m_axis_tdata[YL-1:HL]               = out_handler;
        o_m_axis_tdata[PL-1:YL]               = out_type;
        o_m_axis_tdata[NL-1:PL]               = out_payload;
        o_m_axis_tdata[NL+TIME_WIDTH-1:NL]    = out_now;
    end

endmodule

// File: rtl/teq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module teq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/teq_unit.sv
// Shared unit: ring address add with wrap and due time compare.
module teq_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_head,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_idx,
    input  logic [TIME_WIDTH-1:0]          i_q_time,
    input  logic [TIME_WIDTH-1:0]          i_ref_time,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_addr,
    output logic                           o_gt
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(QUEUE_DEPTH);

    logic [AW:0] sum;
    logic [AW:0] wrapped;

    always_comb begin
        sum     = {1'b0, i_head} + {1'b0, i_idx};
        wrapped = (sum >= DEPTH_W) ? (sum - DEPTH_W) : sum;
        o_addr  = wrapped[AW-1:0];
        o_gt    = i_q_time > i_ref_time;
    end

endmodule

// File: rtl/teq_seq.sv
// Sequencer: insert, pop and clear over the ring RAM, with output register.
module teq_seq #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TIME_WIDTH    = 32,
    parameter int HANDLER_WIDTH = 8,
    parameter int PAYLOAD_WIDTH = 64,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int EW = TIME_WIDTH + HANDLER_WIDTH + teq_pkg::TYPE_W + PAYLOAD_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [teq_pkg::KIND_W-1:0]       i_in_kind,
    input  logic [TIME_WIDTH-1:0]            i_in_time,
    input  logic [HANDLER_WIDTH-1:0]         i_in_handler,
    input  logic [teq_pkg::TYPE_W-1:0]       i_in_type,
    input  logic [PAYLOAD_WIDTH-1:0]         i_in_payload,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [teq_pkg::STATUS_W-1:0]     o_out_status,
    output logic [TIME_WIDTH-1:0]            o_out_event_time,
    output logic [HANDLER_WIDTH-1:0]         o_out_handler,
    output logic [teq_pkg::TYPE_W-1:0]       o_out_type,
    output logic [PAYLOAD_WIDTH-1:0]         o_out_payload,
    output logic [TIME_WIDTH-1:0]            o_out_now,
    output logic                             o_out_last,
    output teq_pkg::t_ram_ctl                o_ram_ctl,
    output logic [EW-1:0]                    o_ram_wdata,
    input  logic [EW-1:0]                    i_ram_q,
    output logic [AW-1:0]                    o_head,
    output logic [AW-1:0]                    o_idx,
    output logic [TIME_WIDTH-1:0]            o_ref_time,
    input  logic [AW-1:0]                    i_addr,
    input  logic                             i_gt
);

    import teq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam int HL = TIME_WIDTH;
    localparam int YL = HL + HANDLER_WIDTH;
    localparam int PL = YL + TYPE_W;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count;
    logic [AW-1:0]             r_head;
    logic [AW-1:0]             r_idx;
    logic [TIME_WIDTH-1:0]     r_time;
    logic [HANDLER_WIDTH-1:0]  r_handler;
    logic [TYPE_W-1:0]         r_type;
    logic [PAYLOAD_WIDTH-1:0]  r_payload;
    logic [STATUS_W-1:0]       r_status;

    logic                      r_out_valid;
    logic [STATUS_W-1:0]       r_out_status;
    logic [TIME_WIDTH-1:0]     r_out_event_time;
    logic [HANDLER_WIDTH-1:0]  r_out_handler;
    logic [TYPE_W-1:0]         r_out_type;
    logic [PAYLOAD_WIDTH-1:0]  r_out_payload;
    logic [TIME_WIDTH-1:0]     r_out_now;
    logic                      r_out_last;

    logic accept;
    logic full;
    logic out_free;
    logic wsel_q;
    logic ins_move;
    logic ins_done;
    logic emit_fire;
    logic emit_resp;

    assign accept   = i_in_valid && o_in_ready;
    assign full     = r_count == FULL_COUNT;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_kind)
                        KIND_SCHEDULE: n_state = full ? S_RESP : S_INS_CHK;
                        KIND_PROCESS:  n_state = S_PRC_CHK;
                        KIND_CLEAR:    n_state = S_RESP;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_CHK: n_state = (r_idx == '0) ? S_RESP : S_INS_CMP;
            S_INS_CMP: n_state = i_gt ? S_INS_CHK : S_RESP;
            S_PRC_CHK: n_state = (r_count == '0) ? S_RESP : S_PRC_CMP;
            S_PRC_CMP: begin
                if (i_gt) begin
                    n_state = S_RESP;
                end else if (out_free) begin
                    n_state = S_PRC_CHK;
                end
            end
            S_RESP: n_state = out_free ? S_IDLE : S_RESP;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ram_ctl = '0;
        o_idx     = '0;
        wsel_q    = 1'b0;
        ins_move  = 1'b0;
        ins_done  = 1'b0;
        emit_fire = 1'b0;
        emit_resp = 1'b0;
        unique case (r_state)
            S_INS_CHK: begin
                if (r_idx == '0) begin
                    o_ram_ctl.we = 1'b1;
                    ins_done     = 1'b1;
                end else begin
                    o_idx        = r_idx - 1'b1;
                    o_ram_ctl.re = 1'b1;
                end
            end
            S_INS_CMP: begin
                o_idx        = r_idx;
                o_ram_ctl.we = 1'b1;
                if (i_gt) begin
                    wsel_q   = 1'b1;
                    ins_move = 1'b1;
                end else begin
                    ins_done = 1'b1;
                end
            end
            S_PRC_CHK: begin
                o_ram_ctl.re = r_count != '0;
            end
            S_PRC_CMP: begin
                o_idx     = AW'(1);
                emit_fire = !i_gt && out_free;
            end
            S_RESP: begin
                emit_resp = out_free;
            end
            default: begin
            end
        endcase
    end

    assign o_ram_wdata = wsel_q ? i_ram_q : {r_payload, r_type, r_handler, r_time};
    assign o_head      = r_head;
    assign o_ref_time  = r_time;
    assign o_in_ready  = r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_in_kind == KIND_CLEAR) begin
                r_count <= '0;
            end else if (ins_done) begin
                r_count <= r_count + 1'b1;
            end else if (emit_fire) begin
                r_count <= r_count - 1'b1;
            end
            if (emit_fire) begin
                r_head <= i_addr;
            end
            if (emit_fire || emit_resp) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_time    <= i_in_time;
            r_handler <= i_in_handler;
            r_type    <= i_in_type;
            r_payload <= i_in_payload;
            r_idx     <= r_count[AW-1:0];
            unique case (i_in_kind)
                KIND_SCHEDULE: r_status <= full ? ST_REJECTED : ST_SCHEDULED;
                KIND_PROCESS:  r_status <= ST_DONE;
                default:       r_status <= ST_CLEARED;
            endcase
        end else if (ins_move) begin
            r_idx <= r_idx - 1'b1;
        end
        if (emit_fire) begin
            r_out_status     <= ST_FIRED;
            r_out_event_time <= i_ram_q[HL-1:0];
            r_out_handler    <= i_ram_q[YL-1:HL];
            r_out_type       <= i_ram_q[PL-1:YL];
            r_out_payload    <= i_ram_q[EW-1:PL];
            r_out_now        <= r_time;
            r_out_last       <= 1'b0;
        end else if (emit_resp) begin
            r_out_status     <= r_status;
            r_out_event_time <= '0;
            r_out_handler    <= '0;
            r_out_type       <= '0;
            r_out_payload    <= '0;
            r_out_now        <= (r_status == ST_DONE) ? r_time : '0;
            r_out_last       <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_status     = r_out_status;
    assign o_out_event_time = r_out_event_time;
    assign o_out_handler    = r_out_handler;
    assign o_out_type       = r_out_type;
    assign o_out_payload    = r_out_payload;
    assign o_out_now        = r_out_now;
    assign o_out_last       = r_out_last;

endmodule

// File: rtl/teq_checker.sv
// Port-level assertions for the timed event queue, bound to the top level.
module teq_checker #(
    parameter int IDW = 112,
    parameter int ODW = 144
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [IDW-1:0]                i_s_axis_tdata,
    input logic [teq_pkg::KIND_W-1:0]    i_s_axis_tuser,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [ODW-1:0]                o_m_axis_tdata,
    input logic [teq_pkg::STATUS_W-1:0]  o_m_axis_tuser,
    input logic                          o_m_axis_tlast
);

    import teq_pkg::*;

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready &&
         (i_s_axis_tuser == KIND_SCHEDULE || i_s_axis_tuser == KIND_PROCESS ||
          i_s_axis_tuser == KIND_CLEAR))
        |=> !o_s_axis_tready)
        else $error("input still ready after a transfer that starts work");

    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == ST_FIRED) |-> !o_m_axis_tlast)
        else $error("fired event marked last");

    a_other_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_FIRED) |-> o_m_axis_tlast)
        else $error("final result not marked last");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind timed_event_queue_top teq_checker #(
    .IDW (IDW),
    .ODW (ODW)
) u_teq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
